@@ hw/rtl/tbee_pkg.sv @@
// shared types, codes and constants of the text buffer edit engine
`default_nettype none

package tbee_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int OP_W   = 3;
    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ST_W   = 2;

    localparam logic [CHAR_W-1:0] NEWLINE = 8'h0A;

    localparam logic [OP_W-1:0] OP_READ = 3'd0;
    localparam logic [OP_W-1:0] OP_INS  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd2;
    localparam logic [OP_W-1:0] OP_COL  = 3'd3;
    localparam logic [OP_W-1:0] OP_LINE = 3'd4;
    localparam logic [OP_W-1:0] OP_NEXT = 3'd5;
    localparam logic [OP_W-1:0] OP_PREV = 3'd6;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_NONE   = 2'd3;

    typedef struct packed {
        logic            load;
        logic            init;
        logic            run;
        logic            fail;
        logic [ST_W-1:0] fail_code;
        logic            finish;
        logic            emit;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic full;
        logic del_none;
        logic is_insert;
        logic is_delete;
        logic done;
    } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/tbee_dpath.sv @@
// datapath: text store, length, scan counters and result registers
`default_nettype none

module tbee_dpath #(
    parameter int DEPTH = tbee_pkg::DEPTH_DEFAULT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  tbee_pkg::cmd_t               cmd,
    output tbee_pkg::sts_t               sts,
    input  wire [tbee_pkg::OP_W-1:0]     op,
    input  wire [tbee_pkg::POS_W-1:0]    position,
    input  wire [tbee_pkg::CHAR_W-1:0]   char_in,
    input  wire [tbee_pkg::POS_W-1:0]    count,
    output logic [tbee_pkg::ST_W-1:0]    status,
    output logic [tbee_pkg::CHAR_W-1:0]  char_out,
    output logic [tbee_pkg::POS_W-1:0]   value_out,
    output logic [tbee_pkg::POS_W-1:0]   length_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = ((LW > tbee_pkg::POS_W) ? LW : tbee_pkg::POS_W) + 1;

    logic [tbee_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [tbee_pkg::CHAR_W-1:0] rdata_reg;

    logic [tbee_pkg::OP_W-1:0]   op_reg;
    logic [tbee_pkg::POS_W-1:0]  pos_reg;
    logic [tbee_pkg::CHAR_W-1:0] ch_reg;
    logic [tbee_pkg::POS_W-1:0]  cnt_reg;

    logic [LW-1:0] len_reg, len_next;
    logic          pend_reg, pend_next;

    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic [AW-1:0] pidx_reg, pidx_next;
    logic [1:0]    hits_reg, hits_next;

    logic [tbee_pkg::ST_W-1:0]   st_res_reg, st_res_next;
    logic [tbee_pkg::CHAR_W-1:0] ch_res_reg, ch_res_next;
    logic [tbee_pkg::POS_W-1:0]  val_res_reg, val_res_next;

    logic [CW-1:0] pos_x, cnt_x, len_x, pidx_x;
    logic [CW-1:0] rd_addr_x, tag_x, col_val, nxt_val, lim_read;
    logic [CW-1:0] del_len;
    logic          is_up, stop, issue_raw, issue, consume, nl;
    logic          we;
    logic [AW-1:0] waddr;
    logic [tbee_pkg::CHAR_W-1:0] wdata;

    assign pos_x  = CW'(pos_reg);
    assign cnt_x  = CW'(cnt_reg);
    assign len_x  = CW'(len_reg);
    assign pidx_x = CW'(pidx_reg);

    assign is_up = (op_reg == tbee_pkg::OP_READ) || (op_reg == tbee_pkg::OP_DEL)
                || (op_reg == tbee_pkg::OP_LINE) || (op_reg == tbee_pkg::OP_NEXT);

    assign sts.bad       = (pos_x > len_x) || (op_reg > tbee_pkg::OP_PREV);
    assign sts.full      = (len_x >= CW'(DEPTH));
    assign sts.del_none  = (cnt_reg == '0) || ((pos_x + cnt_x) > len_x);
    assign sts.is_insert = (op_reg == tbee_pkg::OP_INS);
    assign sts.is_delete = (op_reg == tbee_pkg::OP_DEL);

    assign stop = (((op_reg == tbee_pkg::OP_COL) || (op_reg == tbee_pkg::OP_NEXT))
                   && (hits_reg != 2'd0))
               || ((op_reg == tbee_pkg::OP_PREV) && (hits_reg == 2'd2));

    assign issue_raw = is_up ? (k_reg < lim_reg) : (k_reg > lim_reg);
    assign issue     = cmd.run && issue_raw && !stop;
    assign consume   = cmd.run && pend_reg && !stop;
    assign sts.done  = stop || (!issue_raw && !pend_reg);

    assign rd_addr_x = is_up ? (k_reg + ((op_reg == tbee_pkg::OP_DEL) ? cnt_x : '0))
                             : (k_reg - CW'(1));
    assign tag_x     = (is_up || (op_reg == tbee_pkg::OP_INS)) ? k_reg : (k_reg - CW'(1));
    assign nl        = (rdata_reg == tbee_pkg::NEWLINE);
    assign col_val   = pos_x - pidx_x - CW'(1);
    assign nxt_val   = pidx_x + CW'(1);
    assign lim_read  = (pos_x < len_x) ? (pos_x + CW'(1)) : pos_x;
    assign del_len   = len_x - cnt_x;

    // shifts write during the scan, insert puts its byte in at the end
    assign we    = (consume && ((op_reg == tbee_pkg::OP_INS) || (op_reg == tbee_pkg::OP_DEL)))
                || (cmd.finish && (op_reg == tbee_pkg::OP_INS));
    assign waddr = cmd.finish ? pos_x[AW-1:0] : pidx_reg;
    assign wdata = cmd.finish ? ch_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[rd_addr_x[AW-1:0]];
    end

    always_comb
    begin
        len_next     = len_reg;
        pend_next    = pend_reg;
        k_next       = k_reg;
        lim_next     = lim_reg;
        pidx_next    = pidx_reg;
        hits_next    = hits_reg;
        st_res_next  = st_res_reg;
        ch_res_next  = ch_res_reg;
        val_res_next = val_res_reg;

        if (cmd.init)
        begin
            pend_next    = 1'b0;
            hits_next    = 2'd0;
            st_res_next  = tbee_pkg::ST_OK;
            ch_res_next  = '0;
            val_res_next = '0;
            k_next       = pos_x;
            lim_next     = lim_read;
            case (op_reg)
                tbee_pkg::OP_INS:
                begin
                    k_next   = len_x;
                    lim_next = pos_x;
                end
                tbee_pkg::OP_DEL:
                begin
                    lim_next = del_len;
                end
                tbee_pkg::OP_COL, tbee_pkg::OP_PREV:
                begin
                    lim_next     = '0;
                    val_res_next = pos_reg;
                end
                tbee_pkg::OP_LINE:
                begin
                    k_next   = '0;
                    lim_next = pos_x;
                end
                tbee_pkg::OP_NEXT:
                begin
                    lim_next     = len_x;
                    val_res_next = pos_reg;
                end
                default:
                begin
                    lim_next = lim_read;
                end
            endcase
        end

        if (cmd.fail)
        begin
            st_res_next  = cmd.fail_code;
            ch_res_next  = '0;
            val_res_next = '0;
        end

        if (cmd.run)
        begin
            pend_next = issue;
            if (issue)
            begin
                k_next    = is_up ? (k_reg + CW'(1)) : (k_reg - CW'(1));
                pidx_next = tag_x[AW-1:0];
            end
            if (consume)
            begin
                case (op_reg)
                    tbee_pkg::OP_READ:
                    begin
                        ch_res_next = rdata_reg;
                    end
                    tbee_pkg::OP_COL:
                    begin
                        if (nl)
                        begin
                            val_res_next = col_val[tbee_pkg::POS_W-1:0];
                            hits_next    = 2'd1;
                        end
                    end
                    tbee_pkg::OP_LINE:
                    begin
                        if (nl)
                        begin
                            val_res_next = val_res_reg + tbee_pkg::POS_W'(1);
                        end
                    end
                    tbee_pkg::OP_NEXT:
                    begin
                        if (nl)
                        begin
                            val_res_next = nxt_val[tbee_pkg::POS_W-1:0];
                            hits_next    = 2'd1;
                        end
                    end
                    tbee_pkg::OP_PREV:
                    begin
                        if (nl)
                        begin
                            if (hits_reg == 2'd1)
                            begin
                                val_res_next = nxt_val[tbee_pkg::POS_W-1:0];
                            end
                            hits_next = hits_reg + 2'd1;
                        end
                    end
                    default:
                    begin
                        hits_next = hits_reg;
                    end
                endcase
            end
        end

        if (cmd.finish)
        begin
            case (op_reg)
                tbee_pkg::OP_INS:
                begin
                    len_next = len_reg + LW'(1);
                end
                tbee_pkg::OP_DEL:
                begin
                    len_next = del_len[LW-1:0];
                end
                tbee_pkg::OP_NEXT:
                begin
                    if (hits_reg == 2'd0)
                    begin
                        st_res_next = tbee_pkg::ST_NONE;
                    end
                end
                tbee_pkg::OP_PREV:
                begin
                    if (hits_reg == 2'd0)
                    begin
                        st_res_next = tbee_pkg::ST_NONE;
                    end
                    else if (hits_reg == 2'd1)
                    begin
                        val_res_next = '0;
                    end
                end
                default:
                begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            pos_reg <= position;
            ch_reg  <= char_in;
            cnt_reg <= count;
        end
        k_reg       <= k_next;
        lim_reg     <= lim_next;
        pidx_reg    <= pidx_next;
        hits_reg    <= hits_next;
        st_res_reg  <= st_res_next;
        ch_res_reg  <= ch_res_next;
        val_res_reg <= val_res_next;
        if (cmd.emit)
        begin
            status     <= st_res_reg;
            char_out   <= ch_res_reg;
            value_out  <= val_res_reg;
            length_out <= len_x[tbee_pkg::POS_W-1:0];
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_x <= CW'(DEPTH))
        else $error("length beyond store depth");

    a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (cmd.run || cmd.finish))
        else $error("store written outside a shift or insert");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && (op_reg == tbee_pkg::OP_INS)) |-> (len_x < CW'(DEPTH)))
        else $error("insert finished into a full store");

endmodule

`default_nettype wire

@@ hw/rtl/tbee_ctrl.sv @@
// controller: sequences load, check, scan, finish and result handover
`default_nettype none

module tbee_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire             out_stall,
    input  tbee_pkg::sts_t  sts,
    output tbee_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.fail_code = tbee_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.bad)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = tbee_pkg::ST_BADPOS;
                    state_next    = S_DONE;
                end
                else if (sts.is_insert && sts.full)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = tbee_pkg::ST_FULL;
                    state_next    = S_DONE;
                end
                else if (sts.is_delete && sts.del_none)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = tbee_pkg::ST_NONE;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.init   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.run = 1'b1;
                if (sts.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> slot_free)
        else $error("result emitted over a waiting word");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_CHECK))
        else $error("accepted word not checked next");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("waiting result word dropped");

endmodule

`default_nettype wire

@@ hw/rtl/text_buffer_edit_engine_unit.sv @@
// top level of the text buffer edit engine
// the single store read port walks one character a cycle
// throughput: one word at a time; the next word is taken while the result waits at the output
// reset: length cleared to 0 and both channels idle; store contents stay undefined
`default_nettype none

module text_buffer_edit_engine_unit #(
    parameter int DEPTH = tbee_pkg::DEPTH_DEFAULT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire [tbee_pkg::OP_W-1:0]     op,
    input  wire [tbee_pkg::POS_W-1:0]    position,
    input  wire [tbee_pkg::CHAR_W-1:0]   char_in,
    input  wire [tbee_pkg::POS_W-1:0]    count,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [tbee_pkg::ST_W-1:0]    status,
    output logic [tbee_pkg::CHAR_W-1:0]  char_out,
    output logic [tbee_pkg::POS_W-1:0]   value_out,
    output logic [tbee_pkg::POS_W-1:0]   length_out
);

    tbee_pkg::cmd_t cmd;
    tbee_pkg::sts_t sts;

    tbee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tbee_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .op         (op),
        .position   (position),
        .char_in    (char_in),
        .count      (count),
        .status     (status),
        .char_out   (char_out),
        .value_out  (value_out),
        .length_out (length_out)
    );

endmodule

`default_nettype wire
